// ----- hdl/mnsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mnsp_pkg: shared types and codes for MIDI note span pairing
// Event and span word layouts, event kind codes, span kind codes and the
// structs that travel between the pairing stage and the note table.
// ----------------------------------------------------------------------------
package mnsp_pkg;

   localparam int PITCH_W = 7;
   localparam int DELTA_W = 16;
   localparam int TICK_W  = 32;
   localparam int VOL_W   = 7;
   localparam int KIND_W  = 2;

   // Event kind codes; both codes not named here are treated as damper events.
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;

   // Damper level that means pedal down; any other level means up.
   localparam logic [PITCH_W-1:0] DAMPER_DOWN = 7'd1;

   // Span kind codes.
   localparam logic SPAN_NOTE   = 1'b0;
   localparam logic SPAN_DAMPER = 1'b1;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DELTA_W-1:0] delta_ticks;
      logic [PITCH_W-1:0] pitch_or_level;
      logic [VOL_W-1:0]   velocity;
   } event_type;

   typedef struct packed {
      logic               span_kind;
      logic [PITCH_W-1:0] span_pitch;
      logic [VOL_W-1:0]   span_volume;
      logic [TICK_W-1:0]  start_ticks;
      logic [TICK_W-1:0]  stop_ticks;
   } span_type;

   // One pending note entry.
   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [VOL_W-1:0]  volume;
   } entry_type;

   // Table update issued by the pairing stage.
   typedef struct packed {
      logic               wr_en;
      logic               clr_en;
      logic [PITCH_W-1:0] pitch;
      entry_type          entry;
   } table_upd_type;

endpackage

// ----- hdl/mnsp_chan_if.sv -----
// ----------------------------------------------------------------------------
// mnsp_chan_if: valid/ready channel
// Carries one payload word per handshake; the payload type is set per
// instance.
// ----------------------------------------------------------------------------
interface mnsp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mnsp_note_table.sv -----
// ----------------------------------------------------------------------------
// mnsp_note_table: pending note store
// Start time and volume per pitch in a memory with registered read, valid
// bits in flip-flops, and forwarding of a write that lands on the read edge.
// ----------------------------------------------------------------------------
module mnsp_note_table #(
   parameter int PITCH_COUNT = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [mnsp_pkg::PITCH_W-1:0]  rd_pitch,
   input  logic [mnsp_pkg::PITCH_W-1:0]  look_pitch,
   input  mnsp_pkg::table_upd_type       upd,
   output mnsp_pkg::entry_type           entry,
   output logic                          entry_valid
);
   import mnsp_pkg::*;

   localparam int ADDR_W = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
   localparam logic [ADDR_W:0] DEPTH = (ADDR_W + 1)'(PITCH_COUNT);

   entry_type              mem [PITCH_COUNT];
   logic [PITCH_COUNT-1:0] valid_ff;
   logic [PITCH_COUNT-1:0] valid_in;
   entry_type              rd_data_ff;
   entry_type              fwd_data_ff;
   logic                   fwd_hit_ff;
   logic [ADDR_W-1:0]      upd_idx;
   logic [ADDR_W-1:0]      rd_idx;
   logic [ADDR_W-1:0]      look_idx;

   assign upd_idx  = upd.pitch[ADDR_W-1:0];
   assign rd_idx   = rd_pitch[ADDR_W-1:0];
   assign look_idx = look_pitch[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (upd.wr_en) begin
         mem[upd_idx] <= upd.entry;
      end
   end

   // Read at accept; catch the write of the same edge.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         fwd_data_ff <= upd.entry;
         fwd_hit_ff  <= upd.wr_en && (upd.pitch == rd_pitch);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (upd.wr_en) begin
         valid_in[upd_idx] = 1'b1;
      end
      if (upd.clr_en) begin
         valid_in[upd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry       = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign entry_valid = ({1'b0, look_idx} < DEPTH) ? valid_ff[look_idx] : 1'b0;

endmodule

// ----- hdl/mnsp_span_reg.sv -----
// ----------------------------------------------------------------------------
// mnsp_span_reg: result register
// Holds one span word for the result channel and frees itself as the word
// is taken.
// ----------------------------------------------------------------------------
module mnsp_span_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  mnsp_pkg::span_type   push_data,
   output logic                 push_ready,
   mnsp_chan_if.source          rsp_chan
);
   import mnsp_pkg::*;

   logic     valid_ff;
   span_type data_ff;

   assign push_ready = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push_ready) begin
         valid_ff <= push_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ready) begin
         data_ff <= push_data;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;

endmodule

// ----- hdl/midi_note_span_pairing_top.sv -----
// ----------------------------------------------------------------------------
// midi_note_span_pairing_top: MIDI note on/off pairing into spans
// Span path: pairing stage register, then result register. Throughput: one
// event word per cycle while the result register can take a word, limited by
// the single pairing stage and the note table's one read and one write port.
// Reset clears the running time and all pending flags; no clearing pass.
// ----------------------------------------------------------------------------
module midi_note_span_pairing_top #(
   parameter int PITCH_COUNT = 128
) (
   input  logic        clock,
   input  logic        reset,
   mnsp_chan_if.sink   req_chan,
   mnsp_chan_if.source rsp_chan
);
   import mnsp_pkg::*;

   localparam logic [PITCH_W:0] PITCH_LIMIT = (PITCH_W + 1)'(PITCH_COUNT);

   // Pairing stage: one event word waiting for its table lookup result.
   logic              s1_valid_ff;
   event_type         s1_item_ff;
   logic              s1_fire;
   logic              req_accept;

   // Running time and damper state.
   logic [TICK_W-1:0] time_ff;
   logic [TICK_W-1:0] time_in;
   logic [TICK_W:0]   time_sum;
   logic [TICK_W-1:0] damper_start_ff;
   logic [TICK_W-1:0] damper_start_in;
   logic              damper_valid_ff;
   logic              damper_valid_in;

   logic              in_range;
   entry_type         entry;
   logic              entry_valid;
   table_upd_type     upd;
   logic              has_result;
   span_type          span;
   logic              push_ready;

   // Advance the pairing stage only when the result register can take it.
   assign s1_fire        = s1_valid_ff && push_ready;
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_chan.data;
      end
   end

   // Saturate the running time at its top value.
   assign time_sum = {1'b0, time_ff} + (TICK_W + 1)'(s1_item_ff.delta_ticks);
   assign time_in  = time_sum[TICK_W] ? TICK_MAX : time_sum[TICK_W-1:0];
   assign in_range = {1'b0, s1_item_ff.pitch_or_level} < PITCH_LIMIT;

   always_comb begin
      upd             = '0;
      upd.pitch       = s1_item_ff.pitch_or_level;
      upd.entry       = '{start: time_in, volume: s1_item_ff.velocity};
      has_result      = 1'b0;
      damper_start_in = damper_start_ff;
      damper_valid_in = damper_valid_ff;
      span            = '0;
      span.stop_ticks = time_in;
      unique case (s1_item_ff.kind)
         KIND_NOTE_ON: begin
            // Record start and volume; a repeat overwrites.
            upd.wr_en = s1_fire && in_range;
         end
         KIND_NOTE_OFF: begin
            // Close the pending note; drop an unmatched off.
            has_result       = in_range && entry_valid;
            upd.clr_en       = s1_fire && has_result;
            span.span_kind   = SPAN_NOTE;
            span.span_pitch  = s1_item_ff.pitch_or_level;
            span.span_volume = entry.volume;
            span.start_ticks = entry.start;
         end
         default: begin
            // Damper, including the unused kind code.
            span.span_kind   = SPAN_DAMPER;
            span.start_ticks = damper_start_ff;
            if (s1_item_ff.pitch_or_level == DAMPER_DOWN) begin
               damper_start_in = time_in;
               damper_valid_in = 1'b1;
            end else begin
               has_result      = damper_valid_ff;
               damper_valid_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         damper_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         time_ff         <= time_in;
         damper_valid_ff <= damper_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         damper_start_ff <= damper_start_in;
      end
   end

   mnsp_note_table #(
      .PITCH_COUNT (PITCH_COUNT)
   ) u_note_table (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (req_accept),
      .rd_pitch    (req_chan.data.pitch_or_level),
      .look_pitch  (s1_item_ff.pitch_or_level),
      .upd         (upd),
      .entry       (entry),
      .entry_valid (entry_valid)
   );

   mnsp_span_reg u_span_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_fire && has_result),
      .push_data  (span),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: MIDI note span pairing
// Sends event words into the pairing block and tracks the same running time,
// note table and damper state on the side, so that each span word can be
// compared field by field as it comes out. Directed events cover the corner
// cases, random streams with bursty sending and uneven draining cover the
// rest, and a run of full-scale deltas stretches open spans at the end.
// ----------------------------------------------------------------------------
module testbench;
   import mnsp_pkg::*;

   localparam int PITCH_COUNT     = 128;
   localparam int LATENCY         = 2;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 200;
   localparam int LONG_RUN        = 40;
   localparam int POOL_BASE       = 60;
   localparam int POOL_SIZE       = 8;

   // The package names only the note codes; the other two both mean damper.
   localparam logic [KIND_W-1:0]  KIND_DAMPER = 2'd2;
   localparam logic [KIND_W-1:0]  KIND_SPARE  = 2'd3;
   localparam logic [DELTA_W-1:0] DELTA_MAX   = '1;
   localparam logic [PITCH_W-1:0] LEVEL_UP    = 7'd0;
   localparam logic [PITCH_W-1:0] PITCH_TOP   = 7'd127;
   localparam logic [VOL_W-1:0]   VOL_TOP     = 7'd127;

   typedef enum logic [1:0] {
      SINK_ALWAYS,
      SINK_RANDOM,
      SINK_PATTERN,
      SINK_SPARSE
   } sink_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;

   mnsp_chan_if #(.payload_type(event_type)) req_if ();
   mnsp_chan_if #(.payload_type(span_type))  rsp_if ();

   midi_note_span_pairing_top #(
      .PITCH_COUNT(PITCH_COUNT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always #5 clock = ~clock;

   // Shadow of the block's state, advanced once per accepted event word.
   logic [TICK_W-1:0] tick_now = '0;
   logic [TICK_W-1:0] note_start  [PITCH_COUNT];
   logic [VOL_W-1:0]  note_volume [PITCH_COUNT];
   bit                note_open   [PITCH_COUNT];
   logic [TICK_W-1:0] damper_start = '0;
   bit                damper_open = 1'b0;

   // Span words owed by the block, oldest first.
   span_type owed_spans [$];

   // Sender and receiver behavior, set per test.
   bit            gaps_on = 1'b0;
   int            burst_left = 0;
   sink_mode_type sink_mode = SINK_ALWAYS;
   bit            hold_off_request = 1'b0;
   logic [15:0]   stall_pattern = 16'b1011_0011_1110_0101;

   // Advance the running time and the tables by one event; queue the span it closes.
   function automatic void pair_event(event_type ev);
      logic [TICK_W:0] sum;
      span_type        span;
      sum = {1'b0, tick_now} + (TICK_W + 1)'(ev.delta_ticks);
      // Saturate instead of wrapping.
      tick_now = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
      span = '0;
      span.stop_ticks = tick_now;
      if (ev.kind == KIND_NOTE_ON) begin
         if (ev.pitch_or_level < PITCH_COUNT) begin
            note_start[ev.pitch_or_level]  = tick_now;
            note_volume[ev.pitch_or_level] = ev.velocity;
            note_open[ev.pitch_or_level]   = 1'b1;
         end
      end else if (ev.kind == KIND_NOTE_OFF) begin
         if (ev.pitch_or_level < PITCH_COUNT && note_open[ev.pitch_or_level]) begin
            span.span_kind   = SPAN_NOTE;
            span.span_pitch  = ev.pitch_or_level;
            span.span_volume = note_volume[ev.pitch_or_level];
            span.start_ticks = note_start[ev.pitch_or_level];
            note_open[ev.pitch_or_level] = 1'b0;
            owed_spans = {owed_spans, span};
         end
      end else if (ev.pitch_or_level == DAMPER_DOWN) begin
         // Both remaining kind codes land here.
         damper_start = tick_now;
         damper_open  = 1'b1;
      end else if (damper_open) begin
         span.span_kind   = SPAN_DAMPER;
         span.start_ticks = damper_start;
         damper_open = 1'b0;
         owed_spans = {owed_spans, span};
      end
   endfunction

   function automatic event_type make_event(logic [KIND_W-1:0] kind,
                                            logic [DELTA_W-1:0] delta,
                                            logic [PITCH_W-1:0] pitch_or_level,
                                            logic [VOL_W-1:0] velocity);
      event_type ev;
      ev.kind           = kind;
      ev.delta_ticks    = delta;
      ev.pitch_or_level = pitch_or_level;
      ev.velocity       = velocity;
      return ev;
   endfunction

   // Mostly short deltas, so the running time stays low; zero, full scale
   // and wide values mixed in.
   function automatic logic [DELTA_W-1:0] rand_delta();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return '0;
      if (roll < 3) return DELTA_MAX;
      if (roll < 6) return DELTA_W'($urandom_range(0, 65535));
      return DELTA_W'($urandom_range(1, 960));
   endfunction

   // Weighted toward well-formed on/off and down/up pairs on a small pitch pool,
   // with unmatched offs, repeated ons, odd damper levels and raw noise.
   function automatic event_type random_event();
      event_type          ev;
      int                 roll;
      int                 first;
      logic [PITCH_W-1:0] p;
      roll = $urandom_range(0, 99);
      ev.delta_ticks    = rand_delta();
      ev.pitch_or_level = PITCH_W'($urandom_range(0, 127));
      ev.velocity       = VOL_W'($urandom_range(0, 127));
      ev.kind           = KIND_W'($urandom_range(0, 3));
      if (roll < 35) begin
         ev.kind = KIND_NOTE_ON;
         if ($urandom_range(0, 9) < 7)
            ev.pitch_or_level = PITCH_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
      end else if (roll < 70) begin
         ev.kind = KIND_NOTE_OFF;
         // Close an open note most of the time; otherwise keep the random pitch.
         if (roll < 64) begin
            first = $urandom_range(0, PITCH_COUNT - 1);
            for (int i = 0; i < PITCH_COUNT; i++) begin
               p = PITCH_W'((first + i) % PITCH_COUNT);
               if (note_open[p]) begin
                  ev.pitch_or_level = p;
                  break;
               end
            end
         end
      end else if (roll < 90) begin
         ev.kind = ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_DAMPER;
         if (roll < 80)
            ev.pitch_or_level = DAMPER_DOWN;
         else if (ev.pitch_or_level == DAMPER_DOWN)
            ev.pitch_or_level = LEVEL_UP;
      end
      return ev;
   endfunction

   // Offer one event word at the falling edge, hold it until accepted, then
   // advance the shadow state. Valid stays high so back-to-back words flow.
   task automatic send_event(event_type ev);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data  <= ev;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pair_event(ev);
   endtask

   // Drop valid and hold until every owed span word has come back.
   task automatic wait_for_spans();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (owed_spans.size() != 0)
         @(posedge clock);
   endtask

   // Corner cases: field extremes, every kind code, overwrite and unmatched paths.
   // Pitches beyond PITCH_COUNT cannot be encoded at the full table size.
   task automatic test_directed();
      gaps_on   = 1'b0;
      sink_mode = SINK_ALWAYS;
      // Damper up and note off with nothing pending: no span.
      send_event(make_event(KIND_DAMPER, '0, LEVEL_UP, '0));
      send_event(make_event(KIND_NOTE_OFF, DELTA_MAX, '0, VOL_TOP));
      // Extreme pitches and volumes, then overwrite a pending note.
      send_event(make_event(KIND_NOTE_ON, '0, '0, '0));
      send_event(make_event(KIND_NOTE_ON, 16'd1, PITCH_TOP, VOL_TOP));
      send_event(make_event(KIND_NOTE_ON, 16'hAAAA, '0, 7'h55));
      send_event(make_event(KIND_NOTE_OFF, 16'h5555, '0, 7'h2A));
      send_event(make_event(KIND_NOTE_OFF, DELTA_MAX, PITCH_TOP, '0));
      // Second off for the same pitch is unmatched.
      send_event(make_event(KIND_NOTE_OFF, 16'd3, PITCH_TOP, VOL_TOP));
      // Damper down twice, the second by the spare kind code, then up.
      send_event(make_event(KIND_DAMPER, 16'd7, DAMPER_DOWN, VOL_TOP));
      send_event(make_event(KIND_SPARE, 16'd100, DAMPER_DOWN, '0));
      send_event(make_event(KIND_SPARE, 16'd240, LEVEL_UP, VOL_TOP));
      send_event(make_event(KIND_DAMPER, 16'd480, PITCH_TOP, '0));
      send_event(make_event(KIND_DAMPER, 16'd1, DAMPER_DOWN, '0));
      send_event(make_event(KIND_DAMPER, 16'h8000, 7'd2, '0));
      // Zero-length note; off velocity must not leak into the span.
      send_event(make_event(KIND_NOTE_ON, 16'h00FF, 7'd64, 7'h55));
      send_event(make_event(KIND_NOTE_OFF, '0, 7'd64, VOL_TOP));
      send_event(make_event(KIND_NOTE_ON, 16'h7FFF, 7'd42, 7'h2A));
      send_event(make_event(KIND_NOTE_OFF, 16'd960, 7'd42, 7'h7F));
      // Damper down and up within one tick, with the spare code.
      send_event(make_event(KIND_SPARE, '0, DAMPER_DOWN, '0));
      send_event(make_event(KIND_SPARE, '0, 7'h7E, VOL_TOP));
      wait_for_spans();
   endtask

   // Random streams under each receiver pattern, with and without send gaps.
   task automatic test_random_mix();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               sink_mode = SINK_ALWAYS;
               gaps_on   = 1'b0;
            end
            1: begin
               sink_mode = SINK_RANDOM;
               gaps_on   = 1'b1;
            end
            2: begin
               sink_mode = SINK_PATTERN;
               gaps_on   = 1'b1;
            end
            3: begin
               sink_mode = SINK_SPARSE;
               gaps_on   = 1'b1;
            end
            default: begin
               sink_mode = SINK_RANDOM;
               gaps_on   = 1'b0;
            end
         endcase
         repeat (PHASE_ITEMS)
            send_event(random_event());
      end
   endtask

   // Freeze the receiver while the sender streams closing pairs, so the block
   // backs up and stalls its input; then let it drain.
   task automatic test_hold_off();
      logic [PITCH_W-1:0] pitch;
      sink_mode        = SINK_ALWAYS;
      gaps_on          = 1'b0;
      hold_off_request = 1'b1;
      repeat (30) begin
         pitch = PITCH_W'(POOL_BASE + $urandom_range(0, POOL_SIZE - 1));
         send_event(make_event(KIND_NOTE_ON, rand_delta(), pitch,
                               VOL_W'($urandom_range(0, 127))));
         send_event(make_event(KIND_NOTE_OFF, rand_delta(), pitch,
                               VOL_W'($urandom_range(0, 127))));
      end
      wait_for_spans();
   endtask

   // Short random bursts, each followed by a full drain.
   task automatic test_drain_pauses();
      sink_mode = SINK_RANDOM;
      gaps_on   = 1'b1;
      repeat (8) begin
         repeat (20)
            send_event(random_event());
         wait_for_spans();
      end
   endtask

   // Carry the running time far out with full-scale deltas on words that
   // close nothing, then close spans opened before and after the run. The
   // ceiling itself lies about 65,537 full-scale words out and is not reached.
   task automatic test_long_deltas();
      sink_mode = SINK_ALWAYS;
      gaps_on   = 1'b0;
      send_event(make_event(KIND_NOTE_OFF, '0, PITCH_TOP, '0));
      send_event(make_event(KIND_NOTE_ON, rand_delta(), 7'd9, 7'd99));
      send_event(make_event(KIND_DAMPER, rand_delta(), DAMPER_DOWN, '0));
      repeat (LONG_RUN)
         send_event(make_event(KIND_NOTE_OFF, DELTA_MAX, PITCH_TOP,
                               VOL_W'($urandom_range(0, 127))));
      repeat (3)
         send_event(make_event(KIND_NOTE_OFF, DELTA_MAX, PITCH_TOP,
                               VOL_W'($urandom_range(0, 127))));
      send_event(make_event(KIND_NOTE_OFF, rand_delta(), 7'd9, '0));
      send_event(make_event(KIND_DAMPER, rand_delta(), LEVEL_UP, '0));
      send_event(make_event(KIND_NOTE_ON, DELTA_MAX, 7'd10, 7'd1));
      send_event(make_event(KIND_NOTE_OFF, 16'd5, 7'd10, '0));
      // Keep going with random traffic at the large running time.
      sink_mode = SINK_RANDOM;
      gaps_on   = 1'b1;
      repeat (60)
         send_event(random_event());
      wait_for_spans();
   endtask

   // Receiver: a long hold-off on request, else the current sink mode.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            case (sink_mode)
               SINK_ALWAYS:  rsp_if.ready <= 1'b1;
               SINK_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
               SINK_PATTERN: rsp_if.ready <= stall_pattern[0];
               default:      rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                       logic [TICK_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare every accepted span word with the oldest owed one.
   always @(posedge clock) begin
      span_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (owed_spans.size() == 0) begin
            $error("unexpected span word: %p", rsp_if.data);
            error_count++;
         end else begin
            want = owed_spans.pop_front();
            check_field("span_kind", TICK_W'(want.span_kind),
                        TICK_W'(rsp_if.data.span_kind));
            check_field("span_pitch", TICK_W'(want.span_pitch),
                        TICK_W'(rsp_if.data.span_pitch));
            check_field("span_volume", TICK_W'(want.span_volume),
                        TICK_W'(rsp_if.data.span_volume));
            check_field("start_ticks", want.start_ticks, rsp_if.data.start_ticks);
            check_field("stop_ticks", want.stop_ticks, rsp_if.data.stop_ticks);
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix();
      test_hold_off();
      test_drain_pauses();
      test_long_deltas();

      // Let any stray span word surface before judging.
      wait_for_spans();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mnsp_pkg.sv
hdl/mnsp_chan_if.sv
hdl/mnsp_note_table.sv
hdl/mnsp_span_reg.sv
hdl/midi_note_span_pairing_top.sv
tb/testbench.sv
